/* sv/jmc_pkg.sv */
// Joint move controller package: field widths, item structs, phase,
// command, register index and sequencer codes. No dependencies.
package jmc_pkg;

	localparam int ANGLE_W     = 16;
	localparam int ELAPSED_W   = 16;
	localparam int DIST_W      = 17;
	localparam int SPEED_W     = 24;
	localparam int ACCEL_W     = 32;
	localparam int GAIN_W      = 16;
	localparam int FRAC_W      = 8;
	localparam int LIMIT_W     = 15;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	// shared multiplier: signed A times unsigned B
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
	localparam int FIX_W   = MUL_P_W - 8;

	// speed divider: |diff * 1000| by elapsed_ms
	localparam int DIV_N_W = 27;
	localparam int DIV_D_W = 16;

	localparam logic [MUL_B_W-1:0] SPEED_SCALE = 16'd1000;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'h7FFFFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'h800000;

	localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN       = 16'd256;
	localparam logic [GAIN_W-1:0]  RST_ACCEL_GAIN       = 16'd256;
	localparam logic [FRAC_W-1:0]  RST_ARRIVAL_FRACTION = 8'd26;
	localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT      = 15'd320;
	localparam logic [LIMIT_W-1:0] RST_MIN_ARRIVAL      = 15'd16;

	typedef enum logic [1:0] {
		PH_DRIVE   = 2'd0,
		PH_ARRIVED = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef enum logic {
		CMD_MOVE   = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPEED_GAIN       = 3'd0,
		REG_ACCEL_GAIN       = 3'd1,
		REG_ARRIVAL_FRACTION = 3'd2,
		REG_SPEED_LIMIT      = 3'd3,
		REG_MIN_ARRIVAL      = 3'd4
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARR_MUL,
		ST_ARR_FIX,
		ST_SPD_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_PHASE,
		ST_TS_MUL,
		ST_TS_FIX,
		ST_ERR,
		ST_AC_MUL,
		ST_AC_FIX,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		command_t                    command;
		logic signed [ANGLE_W-1:0]   angle;
		logic [ELAPSED_W-1:0]        elapsed_ms;
	} req_item_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0]   accel;
		phase_t                      phase;
		logic signed [SPEED_W-1:0]   speed;
	} rsp_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* sv/jmc_mul.sv */
// Shared multiplier of the joint move controller: signed by unsigned,
// product registered. Depends on nothing but its parameters.
module jmc_mul #(
	parameter int A_W = 25,
	parameter int B_W = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [A_W-1:0]     a,
	input  logic [B_W-1:0]            b,
	output logic signed [A_W+B_W:0]   product_q
);

	logic signed [A_W+B_W:0] product;

	assign product = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= product;
		end
	end

endmodule

/* sv/jmc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses jmc_pkg for the status struct.
module jmc_div
	import jmc_pkg::*;
#(
	parameter int N_W = 27,
	parameter int D_W = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [N_W-1:0]  dividend,
	input  logic [D_W-1:0]  divisor,
	output div_stat_t       stat,
	output logic [N_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   divisor_q;
	logic [D_W:0]     shifted;
	logic [D_W+1:0]   trial;
	logic             ge;

	assign shifted = {rem_q, quo_q[N_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = !trial[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* sv/joint_move_controller.sv */
// Joint move controller top level: sequencer, move state and registers.
// Depends on jmc_pkg, jmc_mul and jmc_div.
//
// Usage: req carries one item: a new move (target angle) or a measured
// angle sample. An item is taken when req_valid is high and req_stall low.
// A new move gives no result. Every sample gives one
// rsp item: acceleration, phase after the sample and measured speed.
// A sample walks through one shared multiplier and one divider under a
// sequencer. The first sample of a move sets the arrival distance; a later
// one with nonzero elapsed_ms gets its speed from the 27-step divider, one
// with zero elapsed_ms skips it. The drive phase computes target speed and
// acceleration; the arrived phase skips target speed, the done phase both.
// req_stall is high while a sample is in work. The result waits in an
// output register; a new item is accepted while it waits, and the
// sequencer holds at its end while rsp_stall keeps the register full.
// Registers are written through cfg_we, cfg_index, cfg_data; the user must do so
// only while idle, as the block does not enforce it. Reset clears the sequencer,
// loads register defaults and puts the move in the done phase with target angle zero.
module joint_move_controller
	import jmc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  req_item_t               req,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output rsp_item_t               rsp,
	input  logic                    cfg_we,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	function automatic logic signed [FIX_W-1:0] shr8_trunc(
		input logic signed [MUL_P_W-1:0] p
	);
		logic signed [MUL_P_W-1:0] adj;
		adj = p + $signed({{(MUL_P_W-8){1'b0}}, {8{p[MUL_P_W-1]}}});
		return adj[MUL_P_W-1:8];
	endfunction

	seq_state_t state_q, state_d;

	logic [GAIN_W-1:0]  speed_gain_q;
	logic [GAIN_W-1:0]  accel_gain_q;
	logic [FRAC_W-1:0]  arrival_fraction_q;
	logic [LIMIT_W-1:0] speed_limit_q;
	logic [LIMIT_W-1:0] min_arrival_q;

	logic signed [ANGLE_W-1:0] target_q;
	logic signed [ANGLE_W-1:0] prev_q;
	phase_t                    phase_q;
	phase_t                    phase_next;
	logic                      first_q;
	logic                      dir_q;
	logic signed [DIST_W-1:0]  arrival_q;

	logic signed [DIST_W-1:0]  dist_q;
	logic signed [DIST_W-1:0]  diff_q;
	logic [ELAPSED_W-1:0]      elapsed_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [ANGLE_W-1:0] tspeed_q;
	logic signed [MUL_A_W-1:0] err_q;
	logic signed [ACCEL_W-1:0] accel_q;
	logic                      neg_q;

	rsp_item_t rsp_q;
	logic      rsp_valid_q;
	logic      out_free;
	logic      req_accept;

	logic                      mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [MUL_P_W-1:0] product_q;
	logic signed [FIX_W-1:0]   fix;

	logic                      div_start;
	div_stat_t                 div_stat;
	logic [DIV_N_W-1:0]        div_dividend;
	logic [DIV_N_W-1:0]        quotient;
	logic signed [MUL_P_W-1:0] prod_abs;

	logic signed [DIST_W-1:0]  arr_raw;
	logic [DIST_W-1:0]         arr_mag;
	logic signed [FIX_W-1:0]   lim_pos;
	logic signed [FIX_W-1:0]   lim_neg;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign fix          = shr8_trunc(product_q);
	assign prod_abs     = product_q[MUL_P_W-1] ? -product_q : product_q;
	assign div_dividend = prod_abs[DIV_N_W-1:0];
	assign arr_raw      = fix[DIST_W-1:0];
	assign arr_mag      = arr_raw[DIST_W-1] ? DIST_W'(-arr_raw) : DIST_W'(arr_raw);
	assign lim_pos      = $signed({{(FIX_W-LIMIT_W){1'b0}}, speed_limit_q});
	assign lim_neg      = -lim_pos;

	jmc_mul #(
		.A_W(MUL_A_W),
		.B_W(MUL_B_W)
	) u_mul (
		.clk      (clk),
		.en       (mul_en),
		.a        (mul_a),
		.b        (mul_b),
		.product_q(product_q)
	);

	jmc_div #(
		.N_W(DIV_N_W),
		.D_W(DIV_D_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (elapsed_q),
		.stat    (div_stat),
		.quotient(quotient)
	);

	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			PH_DRIVE: begin
				if ((dir_q && dist_q < arrival_q) || (!dir_q && dist_q > arrival_q)) begin
					phase_next = PH_ARRIVED;
				end
			end
			PH_ARRIVED: begin
				if (speed_q > -24'sd16 && speed_q < 24'sd16) begin
					phase_next = PH_DONE;
				end
			end
			default: phase_next = phase_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_accept && req.command == CMD_SAMPLE) begin
					if (first_q) begin
						state_d = ST_ARR_MUL;
					end else if (req.elapsed_ms == '0) begin
						state_d = ST_PHASE;
					end else begin
						state_d = ST_SPD_MUL;
					end
				end
			end
			ST_ARR_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(dist_q);
				mul_b   = MUL_B_W'(arrival_fraction_q);
				state_d = ST_ARR_FIX;
			end
			ST_ARR_FIX: state_d = ST_PHASE;
			ST_SPD_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(diff_q);
				mul_b   = SPEED_SCALE;
				state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_PHASE;
				end
			end
			ST_PHASE: begin
				case (phase_next)
					PH_DRIVE:   state_d = ST_TS_MUL;
					PH_ARRIVED: state_d = ST_ERR;
					default:    state_d = ST_OUT;
				endcase
			end
			ST_TS_MUL: begin
				mul_en  = 1'b1;
				mul_a   = MUL_A_W'(dist_q);
				mul_b   = speed_gain_q;
				state_d = ST_TS_FIX;
			end
			ST_TS_FIX: state_d = ST_ERR;
			ST_ERR:    state_d = ST_AC_MUL;
			ST_AC_MUL: begin
				mul_en  = 1'b1;
				mul_a   = err_q;
				mul_b   = accel_gain_q;
				state_d = ST_AC_FIX;
			end
			ST_AC_FIX: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// registers and move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_gain_q       <= RST_SPEED_GAIN;
			accel_gain_q       <= RST_ACCEL_GAIN;
			arrival_fraction_q <= RST_ARRIVAL_FRACTION;
			speed_limit_q      <= RST_SPEED_LIMIT;
			min_arrival_q      <= RST_MIN_ARRIVAL;
			target_q           <= '0;
			prev_q             <= '0;
			phase_q            <= PH_DONE;
			first_q            <= 1'b1;
			dir_q              <= 1'b0;
			arrival_q          <= '0;
			rsp_valid_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_SPEED_GAIN:       speed_gain_q       <= cfg_data[GAIN_W-1:0];
					REG_ACCEL_GAIN:       accel_gain_q       <= cfg_data[GAIN_W-1:0];
					REG_ARRIVAL_FRACTION: arrival_fraction_q <= cfg_data[FRAC_W-1:0];
					REG_SPEED_LIMIT:      speed_limit_q      <= cfg_data[LIMIT_W-1:0];
					REG_MIN_ARRIVAL:      min_arrival_q      <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (req_accept) begin
				if (req.command == CMD_MOVE) begin
					target_q <= req.angle;
					phase_q  <= PH_DRIVE;
					first_q  <= 1'b1;
				end else begin
					prev_q  <= req.angle;
					first_q <= 1'b0;
				end
			end
			if (state_q == ST_ARR_FIX) begin
				dir_q <= (dist_q > 0);
				if (arr_mag < {{(DIST_W-LIMIT_W){1'b0}}, min_arrival_q}) begin
					arrival_q <= (arr_raw > 0) ?
						$signed({{(DIST_W-LIMIT_W){1'b0}}, min_arrival_q}) :
						-$signed({{(DIST_W-LIMIT_W){1'b0}}, min_arrival_q});
				end else begin
					arrival_q <= arr_raw;
				end
			end
			if (state_q == ST_PHASE) begin
				phase_q <= phase_next;
			end
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// sample datapath
	always_ff @(posedge clk) begin
		if (req_accept) begin
			dist_q    <= DIST_W'(target_q) - DIST_W'(req.angle);
			diff_q    <= DIST_W'(req.angle) - DIST_W'(prev_q);
			elapsed_q <= req.elapsed_ms;
			neg_q     <= (req.angle < prev_q);
			if (first_q) begin
				speed_q <= '0;
			end else if (req.angle > prev_q) begin
				speed_q <= SPEED_MAX;
			end else if (req.angle < prev_q) begin
				speed_q <= SPEED_MIN;
			end else begin
				speed_q <= '0;
			end
		end
		if (state_q == ST_DIV_WAIT && div_stat.done) begin
			if (quotient[DIV_N_W-1:SPEED_W-1] != '0) begin
				speed_q <= neg_q ? SPEED_MIN : SPEED_MAX;
			end else if (neg_q) begin
				speed_q <= -$signed({1'b0, quotient[SPEED_W-2:0]});
			end else begin
				speed_q <= $signed({1'b0, quotient[SPEED_W-2:0]});
			end
		end
		if (state_q == ST_PHASE) begin
			tspeed_q <= '0;
			accel_q  <= '0;
		end
		if (state_q == ST_TS_FIX) begin
			if (fix > lim_pos) begin
				tspeed_q <= ANGLE_W'(lim_pos);
			end else if (fix < lim_neg) begin
				tspeed_q <= ANGLE_W'(lim_neg);
			end else begin
				tspeed_q <= ANGLE_W'(fix);
			end
		end
		if (state_q == ST_ERR) begin
			err_q <= MUL_A_W'(tspeed_q) - MUL_A_W'(speed_q);
		end
		if (state_q == ST_AC_FIX) begin
			if (fix[FIX_W-1:ACCEL_W-1] == '0 || fix[FIX_W-1:ACCEL_W-1] == '1) begin
				accel_q <= fix[ACCEL_W-1:0];
			end else begin
				accel_q <= fix[FIX_W-1] ? {1'b1, {(ACCEL_W-1){1'b0}}} :
					{1'b0, {(ACCEL_W-1){1'b1}}};
			end
		end
		if (state_q == ST_OUT && out_free) begin
			rsp_q.accel <= accel_q;
			rsp_q.phase <= phase_q;
			rsp_q.speed <= speed_q;
		end
	end

`ifndef SYNTHESIS
	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

	a_done_no_accel: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.phase == PH_DONE) |-> (rsp.accel == '0))
		else $error("nonzero accel in done phase");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_div_wait_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_WAIT) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");
`endif

endmodule
